// ----- hdl/fsrf_pkg.sv -----
// Shared package for the frame store rectangle fill block.
// Holds default screen size, command codes and the controller/datapath bundles.
// No dependencies.
package fsrf_pkg;

   // Default screen size in pixels
   localparam int DEFAULT_SCREEN_WIDTH  = 240;
   localparam int DEFAULT_SCREEN_HEIGHT = 320;

   // Field widths on the request and response channels
   localparam int COORD_W     = 16;
   localparam int PIXEL_W     = 16;
   localparam int CMD_W       = 2;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 24;

   // Command codes carried in a request
   typedef enum logic [CMD_W-1:0] {
      CMD_FILL  = 2'd0,
      CMD_PLOT  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_code_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;    // capture the accepted request
      logic load_clear;  // set up a full-screen fill with zero
      logic step;        // advance the fill walk by one pixel
      logic wr;          // write the current pixel
      logic rd;          // read the current pixel
      logic load_rsp;    // load the response register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic fill_last;   // current pixel is the last of the rectangle
      logic drop;        // captured plot lies off screen
   } dp_status_type;

endpackage

// ----- hdl/fsrf_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the pixel frame store. No dependencies.
module fsrf_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // At most one write and one read per cycle, at the one address; read data is held until the next read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      if (re) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fsrf_ctrl.sv -----
// Controller state machine for the frame store rectangle fill block.
// Sequences the clearing pass, fills, plots, reads and responses.
// Depends on fsrf_pkg.
module fsrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fsrf_pkg::cmd_code_type req_command,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output fsrf_pkg::dp_cmd_type   dp_cmd,
   input  fsrf_pkg::dp_status_type dp_status
);
   import fsrf_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_PLOT,
      ST_READ,
      ST_RESPOND
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;
   logic      rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dp_cmd       = '0;
      case (state_ff)
         ST_INIT: begin
            dp_cmd.load_clear = 1'b1;
            state_in          = ST_CLEAR;
         end
         ST_CLEAR: begin
            dp_cmd.wr   = 1'b1;
            dp_cmd.step = 1'b1;
            if (dp_status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               dp_cmd.load_req = 1'b1;
               case (req_command)
                  CMD_FILL: state_in = ST_FILL;
                  CMD_PLOT: state_in = ST_PLOT;
                  CMD_READ: state_in = ST_READ;
                  default:  state_in = ST_RESPOND;
               endcase
            end
         end
         ST_FILL: begin
            dp_cmd.wr   = 1'b1;
            dp_cmd.step = 1'b1;
            if (dp_status.fill_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_PLOT: begin
            dp_cmd.wr = !dp_status.drop;
            state_in  = ST_RESPOND;
         end
         ST_READ: begin
            dp_cmd.rd = 1'b1;
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            // Wait until the response register is free
            if (rsp_free) begin
               dp_cmd.load_rsp = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // State and registered response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/fsrf_datapath.sv -----
// Datapath for the frame store rectangle fill block: clamping, corner ordering,
// the pixel walk, frame store addressing and the response register.
// Depends on fsrf_pkg.
module fsrf_datapath #(
   parameter int SCREEN_WIDTH  = fsrf_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = fsrf_pkg::DEFAULT_SCREEN_HEIGHT,
   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fsrf_pkg::cmd_code_type            req_command,
   input  logic [fsrf_pkg::COORD_W-1:0]      req_x_start,
   input  logic [fsrf_pkg::COORD_W-1:0]      req_y_start,
   input  logic [fsrf_pkg::COORD_W-1:0]      req_x_end,
   input  logic [fsrf_pkg::COORD_W-1:0]      req_y_end,
   input  logic [fsrf_pkg::PIXEL_W-1:0]      req_color,
   input  fsrf_pkg::dp_cmd_type              dp_cmd,
   output fsrf_pkg::dp_status_type           dp_status,
   output logic                              ram_we,
   output logic                              ram_re,
   output logic [ADDR_W-1:0]                 ram_addr,
   output logic [fsrf_pkg::PIXEL_W-1:0]      ram_wr_data,
   input  logic [fsrf_pkg::PIXEL_W-1:0]      ram_rd_data,
   output logic [fsrf_pkg::PIXEL_W-1:0]      rsp_read_color,
   output logic                              rsp_was_dropped
);
   import fsrf_pkg::*;

   localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   x0_ff, x0_in;
   logic [COL_W-1:0]   x1_ff, x1_in;
   logic [ROW_W-1:0]   y1_ff, y1_in;
   logic [PIXEL_W-1:0] color_ff, color_in;
   logic               drop_ff, drop_in;
   logic               is_read_ff, is_read_in;
   logic [PIXEL_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic               is_fill;
   logic               xs_off, ys_off;
   logic [COL_W-1:0]   xs_c, xe_c;
   logic [ROW_W-1:0]   ys_c, ye_c;
   logic               row_end;

   // Clamp each coordinate to the last column or row; non-fill commands use
   // the start corner for both corners.
   assign is_fill = (req_command == CMD_FILL);
   assign xs_off  = (req_x_start >= COORD_W'(SCREEN_WIDTH));
   assign ys_off  = (req_y_start >= COORD_W'(SCREEN_HEIGHT));
   assign xs_c    = xs_off ? LAST_COL : req_x_start[COL_W-1:0];
   assign ys_c    = ys_off ? LAST_ROW : req_y_start[ROW_W-1:0];
   assign xe_c    = !is_fill ? xs_c :
                    (req_x_end >= COORD_W'(SCREEN_WIDTH)) ? LAST_COL : req_x_end[COL_W-1:0];
   assign ye_c    = !is_fill ? ys_c :
                    (req_y_end >= COORD_W'(SCREEN_HEIGHT)) ? LAST_ROW : req_y_end[ROW_W-1:0];

   assign row_end             = (col_ff == x1_ff);
   assign dp_status.fill_last = row_end && (row_ff == y1_ff);
   assign dp_status.drop      = drop_ff;

   // Rectangle set-up and the row-major pixel walk
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      color_in     = color_ff;
      drop_in      = drop_ff;
      is_read_in   = is_read_ff;
      rsp_color_in = rsp_color_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (dp_cmd.load_req) begin
         x0_in      = (xs_c > xe_c) ? xe_c : xs_c;
         x1_in      = (xs_c > xe_c) ? xs_c : xe_c;
         col_in     = (xs_c > xe_c) ? xe_c : xs_c;
         row_in     = (ys_c > ye_c) ? ye_c : ys_c;
         y1_in      = (ys_c > ye_c) ? ys_c : ye_c;
         color_in   = req_color;
         drop_in    = (req_command == CMD_PLOT) && (xs_off || ys_off);
         is_read_in = (req_command == CMD_READ);
      end else if (dp_cmd.load_clear) begin
         x0_in      = '0;
         x1_in      = LAST_COL;
         col_in     = '0;
         row_in     = '0;
         y1_in      = LAST_ROW;
         color_in   = '0;
         drop_in    = 1'b0;
         is_read_in = 1'b0;
      end else if (dp_cmd.step) begin
         if (row_end) begin
            col_in = x0_ff;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // Response: stored pixel for a read, zero otherwise
      if (dp_cmd.load_rsp) begin
         rsp_color_in = is_read_ff ? ram_rd_data : '0;
         rsp_drop_in  = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= 1'b0;
      end else begin
         drop_ff <= drop_in;
      end
      col_ff       <= col_in;
      row_ff       <= row_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      color_ff     <= color_in;
      is_read_ff   <= is_read_in;
      rsp_color_ff <= rsp_color_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // Row-major frame store address
   assign ram_addr    = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(col_ff);
   assign ram_we      = dp_cmd.wr;
   assign ram_re      = dp_cmd.rd;
   assign ram_wr_data = color_ff;

   assign rsp_read_color  = rsp_color_ff;
   assign rsp_was_dropped = rsp_drop_ff;

endmodule

// ----- hdl/frame_store_rectangle_fill_top.sv -----
// Channel   Direction  Signals                          Content
// request   in         req_tvalid/req_tready/req_tdata  one command per request
// response  out        rsp_tvalid/rsp_tready/rsp_tdata  one result per request
//
// A plot or read request passes through its own state and then the respond
// state, which loads the response register; a fill writes its rectangle with
// one frame store write per cycle through the single RAM port. After reset a
// clearing pass writes zero to every pixel, and no request is accepted meanwhile.
// A finished response waits in its output register while the next request is
// accepted; a stalled response holds back only the following response.
//
// Top level of the frame store rectangle fill block.
// Depends on fsrf_pkg, fsrf_ram, fsrf_ctrl and fsrf_datapath.
module frame_store_rectangle_fill_top #(
   parameter int SCREEN_WIDTH  = fsrf_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = fsrf_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // command[1:0], x_start[17:2], y_start[33:18], x_end[49:34], y_end[65:50],
   // color[81:66], zero padding [87:82]
   input  logic [fsrf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_color[15:0], was_dropped[16], zero padding [23:17]
   output logic [fsrf_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import fsrf_pkg::*;

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_code_type       req_command;
   dp_cmd_type         dp_cmd;
   dp_status_type      dp_status;
   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_addr;
   logic [PIXEL_W-1:0] ram_wr_data;
   logic [PIXEL_W-1:0] ram_rd_data;
   logic [PIXEL_W-1:0] rsp_read_color;
   logic               rsp_was_dropped;

   assign req_command = cmd_code_type'(req_tdata[1:0]);

   // Controller
   fsrf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_command),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   // Datapath
   fsrf_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_x_start     (req_tdata[17:2]),
      .req_y_start     (req_tdata[33:18]),
      .req_x_end       (req_tdata[49:34]),
      .req_y_end       (req_tdata[65:50]),
      .req_color       (req_tdata[81:66]),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .ram_we          (ram_we),
      .ram_re          (ram_re),
      .ram_addr        (ram_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_data     (ram_rd_data),
      .rsp_read_color  (rsp_read_color),
      .rsp_was_dropped (rsp_was_dropped)
   );

   // Pixel frame store
   fsrf_ram #(
      .DATA_W (PIXEL_W),
      .DEPTH  (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .we      (ram_we),
      .re      (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // Response packing
   assign rsp_tdata = {7'd0, rsp_was_dropped, rsp_read_color};

`ifndef ASSERT_OFF
   // No request is taken while the frame store is being written.
   a_no_accept_during_write: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !ram_we)
      else $error("request accepted during a frame store write");

   // An off-screen plot never reaches the frame store.
   a_drop_no_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !dp_status.drop)
      else $error("dropped plot written to the frame store");

   // A dropped plot reports no pixel value.
   a_drop_zero_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[16]) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("dropped plot carries a pixel value");
`endif

endmodule
